// ----- sv/gbba_pkg.sv -----
// ---------------------------------------------------------------------------
// gbba_pkg
// Shared types and constants of the grouped bitmap block allocator: channel
// item formats, operation and register codes, and the bitmap word layout.
// ---------------------------------------------------------------------------
package gbba_pkg;

   // Bitmap words are bytes; block offset 0 of a word sits in its top bit.
   localparam int WORD_BITS = 8;
   localparam int OFS_W     = 3;

   // Global block numbers on the channels.
   localparam int LOC_W = 15;

   // Configuration registers.
   localparam int CFG_W      = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] CFG_RESERVED_RST = 13'd2;
   localparam logic [CFG_W-1:0] CFG_EXTRA_RST    = 13'd3;

   // Register index, taken from the word address.
   localparam logic REG_RESERVED = 1'b0;
   localparam logic REG_EXTRA    = 1'b1;

   // Operation codes.
   localparam logic [1:0] FUNC_FORMAT = 2'd0;
   localparam logic [1:0] FUNC_ALLOC  = 2'd1;
   localparam logic [1:0] FUNC_FREE   = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic             hit;
      logic [OFS_W-1:0] ofs;
      word_type         word_set;
   } pick_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [2:0]       preferred_group;
      logic [4:0]       block_count;
      logic [LOC_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [LOC_W-1:0] block_location;
      logic             valid_res;
      logic             last;
      logic             shortfall;
   } rsp_type;

endpackage

// ----- sv/grouped_bitmap_block_allocator_top.sv -----
// ---------------------------------------------------------------------------
// grouped_bitmap_block_allocator_top
// First-fit block allocator over a used-bitmap split into groups, each with
// a free count, driven by a small sequencer around one free-bit picker.
// ---------------------------------------------------------------------------
// Usage:
// An item on the req channel is a format, allocate or free operation. Only
// allocate returns results on the rsp channel: one item per block found, or
// a single item with valid_res low when nothing was found or nothing asked.
// The bitmap lives in a RAM of byte words, GROUPS times ceil(GROUP_BLOCKS / 8)
// rounded up to a power of two (4096 with the default parameters).
// Reset starts a clearing pass over that RAM, one word per cycle, while
// req_stall stays high; a format item starts the same pass.
// An allocate visits the preferred group first, then the others in order;
// in each group with free blocks it reads the bitmap words in turn and takes
// free blocks from them, then it delivers the result items.
// A free finds the group by repeated subtraction, then updates the bitmap
// word and the free count.
// The block works on one item at a time: req_stall is low only when idle.
// Results sit in an output register; while rsp_stall is high the sequencer
// waits and the register holds its item. A new request can be taken while
// the last result of the previous one is still waiting.
// Registers are to be written through the APB-style port only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module grouped_bitmap_block_allocator_top
   import gbba_pkg::*;
#(
   parameter int GROUPS       = 8,
   parameter int GROUP_BLOCKS = 4096,
   parameter int MAX_REQUEST  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int WPG      = (GROUP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WPG_W    = (WPG > 1) ? $clog2(WPG) : 1;
   localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int IT_W     = $clog2(GROUPS + 1);
   localparam int CNT_W    = $clog2(GROUP_BLOCKS + 1);
   localparam int REQ_W    = $clog2(MAX_REQUEST + 1);
   localparam int LOC_AW   = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
   localparam int BM_DEPTH = GROUPS * (2 ** WPG_W);
   localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DIV     = 4'd2;
   localparam logic [3:0] S_FREE_RD = 4'd3;
   localparam logic [3:0] S_FREE_WR = 4'd4;
   localparam logic [3:0] S_GSEL    = 4'd5;
   localparam logic [3:0] S_GCHK    = 4'd6;
   localparam logic [3:0] S_SRD     = 4'd7;
   localparam logic [3:0] S_SWORD   = 4'd8;
   localparam logic [3:0] S_EMIT_RD = 4'd9;
   localparam logic [3:0] S_EMIT_LD = 4'd10;
   localparam logic [3:0] S_EMPTY   = 4'd11;

   // Control state.
   logic [3:0]       state_ff, state_in;
   logic [GRP_W-1:0] cur_g_ff, cur_g_in;
   logic [WPG_W-1:0] sw_ff, sw_in;
   logic             zero_ff, zero_in;
   logic             pref_phase_ff, pref_phase_in;
   logic [IT_W-1:0]  iter_ff, iter_in;
   logic [REQ_W-1:0] found_ff, found_in;
   logic [REQ_W-1:0] want_ff, want_in;
   logic [REQ_W-1:0] k_ff, k_in;
   logic             fresh_ff, fresh_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0] rsv_ff, rsv_in;
   logic [CFG_W-1:0] ext_ff, ext_in;

   // Payload state.
   word_type         word_ff, word_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LOC_W-1:0] base_ff, base_in;
   logic [LOC_W-1:0] rem_ff, rem_in;
   logic [2:0]       pref_ff, pref_in;
   logic             short_ff, short_in;
   rsp_type          rsp_item_ff, rsp_item_in;

   // Memory ports.
   logic             bm_we;
   word_type         bm_wdata;
   word_type         bm_rd;
   logic [BM_AW-1:0] bm_addr;
   logic             cnt_we;
   logic [CNT_W-1:0] cnt_wdata;
   logic [CNT_W-1:0] cnt_rd;
   logic             loc_we;
   logic [LOC_W-1:0] loc_wdata;
   logic [LOC_W-1:0] loc_rd;

   // Datapath helpers.
   word_type         cur_word;
   word_type         vmask;
   word_type         fmt_mask;
   word_type         word_clr;
   pick_type         pick;
   logic [CFG_W:0]   res_sum;
   logic [CNT_W-1:0] res;
   logic [CNT_W-1:0] fmt_cnt;
   logic [CNT_W-1:0] cnt_inc;
   logic             can_take;
   logic             end_group;
   logic             out_free;
   logic             csr_idx;
   logic             csr_wr;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1];
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      rsv_in = rsv_ff;
      ext_in = ext_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_RESERVED: rsv_in = pwdata[CFG_W-1:0];
            REG_EXTRA:    ext_in = pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_RESERVED: prdata = {{(CSR_DATA_W - CFG_W){1'b0}}, rsv_ff};
         REG_EXTRA:    prdata = {{(CSR_DATA_W - CFG_W){1'b0}}, ext_ff};
      endcase
   end

   // ------------------------------------------------------------------
   // Memories: bitmap words, free counts, found locations
   // ------------------------------------------------------------------
   // Every bitmap access of every operation goes to the word under the
   // group and word counters.
   assign bm_addr = BM_AW'({cur_g_ff, sw_ff});

   gbba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BM_DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_addr),
      .wr_data (bm_wdata),
      .rd_addr (bm_addr),
      .rd_data (bm_rd)
   );

   // The count is read at the group that the sequencer moves to, so the
   // data is ready in the cycle after the group is chosen.
   gbba_ram #(
      .WIDTH (CNT_W),
      .DEPTH (GROUPS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cur_g_ff),
      .wr_data (cnt_wdata),
      .rd_addr (cur_g_in),
      .rd_data (cnt_rd)
   );

   gbba_ram #(
      .WIDTH (LOC_W),
      .DEPTH (MAX_REQUEST)
   ) u_locs (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (LOC_AW'(found_ff)),
      .wr_data (loc_wdata),
      .rd_addr (LOC_AW'(k_ff)),
      .rd_data (loc_rd)
   );

   // ------------------------------------------------------------------
   // Word datapath
   // ------------------------------------------------------------------
   assign cur_word = fresh_ff ? bm_rd : word_ff;

   always_comb begin
      res_sum = {1'b0, rsv_ff} + ((cur_g_ff == '0) ? {1'b0, ext_ff} : '0);
      if (zero_ff) begin
         res = '0;
      end else if (32'(res_sum) > GROUP_BLOCKS) begin
         res = CNT_W'(GROUP_BLOCKS);
      end else begin
         res = CNT_W'(res_sum);
      end
      fmt_cnt = zero_ff ? '0 : (CNT_W'(GROUP_BLOCKS) - res);
      // Positions past the end of the group in its last word are never free.
      for (int j = 0; j < WORD_BITS; j++) begin
         vmask[WORD_BITS-1-j]    = ((32'(sw_ff) * WORD_BITS) + j) < GROUP_BLOCKS;
         fmt_mask[WORD_BITS-1-j] = ((32'(sw_ff) * WORD_BITS) + j) < 32'(res);
      end
   end

   gbba_pick u_pick (
      .word  (cur_word),
      .vmask (vmask),
      .pick  (pick)
   );

   always_comb begin
      word_clr = bm_rd;
      word_clr[OFS_W'(WORD_BITS - 1) - rem_ff[OFS_W-1:0]] = 1'b0;
   end

   assign cnt_inc   = (cnt_rd < CNT_W'(GROUP_BLOCKS)) ? (cnt_rd + 1'b1) : cnt_rd;
   assign can_take  = pick.hit && (found_ff != want_ff) && (cnt_ff != '0);
   assign end_group = (found_ff == want_ff) || (cnt_ff == '0) ||
                      (sw_ff == WPG_W'(WPG - 1));
   assign loc_wdata = base_ff + LOC_W'({sw_ff, pick.ofs});
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cur_g_in      = cur_g_ff;
      sw_in         = sw_ff;
      zero_in       = zero_ff;
      pref_phase_in = pref_phase_ff;
      iter_in       = iter_ff;
      found_in      = found_ff;
      want_in       = want_ff;
      k_in          = k_ff;
      fresh_in      = fresh_ff;
      word_in       = word_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      rem_in        = rem_ff;
      pref_in       = pref_ff;
      short_in      = short_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      bm_we         = 1'b0;
      bm_wdata      = cur_word;
      cnt_we        = 1'b0;
      cnt_wdata     = cnt_ff;
      loc_we        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            bm_we    = 1'b1;
            bm_wdata = fmt_mask;
            if (sw_ff == '0) begin
               cnt_we    = 1'b1;
               cnt_wdata = fmt_cnt;
            end
            if (sw_ff == WPG_W'(WPG - 1)) begin
               sw_in = '0;
               if (cur_g_ff == GRP_W'(GROUPS - 1)) begin
                  state_in = S_IDLE;
                  zero_in  = 1'b0;
               end else begin
                  cur_g_in = cur_g_ff + 1'b1;
               end
            end else begin
               sw_in = sw_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               unique case (req_item.func)
                  FUNC_FORMAT: begin
                     cur_g_in = '0;
                     sw_in    = '0;
                     zero_in  = 1'b0;
                     state_in = S_CLEAR;
                  end
                  FUNC_ALLOC: begin
                     pref_in       = req_item.preferred_group;
                     want_in       = (32'(req_item.block_count) > MAX_REQUEST) ?
                                     REQ_W'(MAX_REQUEST) : REQ_W'(req_item.block_count);
                     found_in      = '0;
                     iter_in       = '0;
                     pref_phase_in = 1'b1;
                     state_in      = S_GSEL;
                  end
                  FUNC_FREE: begin
                     rem_in   = req_item.block_number;
                     cur_g_in = '0;
                     state_in = S_DIV;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Split the block number into group and index by subtraction.
         S_DIV: begin
            if (32'(rem_ff) < GROUP_BLOCKS) begin
               sw_in    = WPG_W'(rem_ff >> OFS_W);
               state_in = S_FREE_RD;
            end else if (cur_g_ff == GRP_W'(GROUPS - 1)) begin
               state_in = S_IDLE;
            end else begin
               rem_in   = rem_ff - LOC_W'(GROUP_BLOCKS);
               cur_g_in = cur_g_ff + 1'b1;
            end
         end

         S_FREE_RD: begin
            state_in = S_FREE_WR;
         end

         S_FREE_WR: begin
            bm_we     = 1'b1;
            bm_wdata  = word_clr;
            cnt_we    = 1'b1;
            cnt_wdata = cnt_inc;
            state_in  = S_IDLE;
         end

         // The preferred group goes first, then the others in order.
         S_GSEL: begin
            if ((found_ff == want_ff) ||
                (!pref_phase_ff && (iter_ff == IT_W'(GROUPS)))) begin
               short_in = found_ff < want_ff;
               k_in     = '0;
               state_in = (found_ff == '0) ? S_EMPTY : S_EMIT_RD;
            end else if (pref_phase_ff) begin
               pref_phase_in = 1'b0;
               if (32'(pref_ff) < GROUPS) begin
                  cur_g_in = GRP_W'(pref_ff);
                  state_in = S_GCHK;
               end
            end else if (32'(iter_ff) == 32'(pref_ff)) begin
               iter_in = iter_ff + 1'b1;
            end else begin
               cur_g_in = GRP_W'(iter_ff);
               iter_in  = iter_ff + 1'b1;
               state_in = S_GCHK;
            end
         end

         S_GCHK: begin
            if (cnt_rd == '0) begin
               state_in = S_GSEL;
            end else begin
               cnt_in   = cnt_rd;
               sw_in    = '0;
               base_in  = LOC_W'(32'(cur_g_ff) * GROUP_BLOCKS);
               state_in = S_SRD;
            end
         end

         S_SRD: begin
            fresh_in = 1'b1;
            state_in = S_SWORD;
         end

         // Take one free block per cycle; write the word back once it has
         // nothing more to give or no more blocks are wanted.
         S_SWORD: begin
            fresh_in = 1'b0;
            if (can_take) begin
               word_in  = pick.word_set;
               loc_we   = 1'b1;
               found_in = found_ff + 1'b1;
               cnt_in   = cnt_ff - 1'b1;
            end else begin
               bm_we    = 1'b1;
               bm_wdata = cur_word;
               if (end_group) begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_ff;
                  state_in  = S_GSEL;
               end else begin
                  sw_in    = sw_ff + 1'b1;
                  state_in = S_SRD;
               end
            end
         end

         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end

         S_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.block_location = loc_rd;
               rsp_item_in.valid_res      = 1'b1;
               rsp_item_in.last           = (k_ff + 1'b1) == found_ff;
               rsp_item_in.shortfall      = short_ff;
               if ((k_ff + 1'b1) == found_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end

         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.block_location = '0;
               rsp_item_in.valid_res      = 1'b0;
               rsp_item_in.last           = 1'b1;
               rsp_item_in.shortfall      = short_ff;
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cur_g_ff      <= '0;
         sw_ff         <= '0;
         zero_ff       <= 1'b1;
         pref_phase_ff <= 1'b0;
         iter_ff       <= '0;
         found_ff      <= '0;
         want_ff       <= '0;
         k_ff          <= '0;
         fresh_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsv_ff        <= CFG_RESERVED_RST;
         ext_ff        <= CFG_EXTRA_RST;
      end else begin
         state_ff      <= state_in;
         cur_g_ff      <= cur_g_in;
         sw_ff         <= sw_in;
         zero_ff       <= zero_in;
         pref_phase_ff <= pref_phase_in;
         iter_ff       <= iter_in;
         found_ff      <= found_in;
         want_ff       <= want_in;
         k_ff          <= k_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsv_ff        <= rsv_in;
         ext_ff        <= ext_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      pref_ff     <= pref_in;
      short_ff    <= short_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sv/gbba_ram.sv -----
// ---------------------------------------------------------------------------
// gbba_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module gbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gbba_pick.sv -----
// ---------------------------------------------------------------------------
// gbba_pick
// Free-bit picker shared by every allocation step: finds the lowest free
// block offset of a bitmap word and returns the word with that bit set.
// ---------------------------------------------------------------------------
module gbba_pick
   import gbba_pkg::*;
(
   input  word_type word,
   input  word_type vmask,
   output pick_type pick
);

   word_type free_bits;

   always_comb begin
      free_bits     = ~word & vmask;
      pick.hit      = 1'b0;
      pick.ofs      = '0;
      // Walk from the highest offset down so that the lowest offset wins.
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (free_bits[WORD_BITS-1-j]) begin
            pick.hit = 1'b1;
            pick.ofs = OFS_W'(j);
         end
      end
      pick.word_set = word;
      if (pick.hit) begin
         pick.word_set[OFS_W'(WORD_BITS - 1) - pick.ofs] = 1'b1;
      end
   end

endmodule
